>>> rtl/cdf_pkg.sv
`timescale 1ns / 1ps

package cdf_pkg;

    localparam int CEP_SIZE_DFLT        = 13;
    localparam int MAX_HALF_WINDOW_DFLT = 4;
    localparam int SAMPLE_BITS_DFLT     = 16;

    localparam int COEF_W   = 16;
    localparam int FEAT_W   = 18;
    localparam int FIDX_W   = 6;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    localparam int MAX_RES  = 4;
    localparam int RQ_DEPTH = 16;
    localparam int NTAP     = 9;

    localparam logic [CFG_IDX_W-1:0] REG_FEATURE_MODE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COEFS_USED   = CFG_IDX_W'(1);

    localparam logic [3:0] USED_RESET = 4'd13;

    typedef enum logic [1:0] {
        MODE_CEP       = 2'd0,
        MODE_CEP_DELTA = 2'd1,
        MODE_LAYOUT39  = 2'd2,
        MODE_LAYOUT51  = 2'd3
    } t_mode;

    typedef struct packed {
        logic signed [FEAT_W-1:0] feature_value;
        logic [FIDX_W-1:0]        feature_index;
        logic                     frame_done;
    } t_res;

    function automatic logic [3:0] f_win_need(input t_mode m);
        logic [3:0] r;
        unique case (m)
            MODE_CEP:       r = 4'd1;
            MODE_CEP_DELTA: r = 4'd5;
            MODE_LAYOUT39:  r = 4'd7;
            MODE_LAYOUT51:  r = 4'd9;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/cdf_if.sv
`timescale 1ns / 1ps

interface cdf_in_if import cdf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [COEF_W-1:0] coef_value;

    modport source (output valid, output coef_value, input ready);
    modport sink   (input valid, input coef_value, output ready);
endinterface

interface cdf_out_if import cdf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [FEAT_W-1:0] feature_value;
    logic [FIDX_W-1:0]        feature_index;
    logic                     frame_done;

    modport source (output valid, output feature_value, output feature_index,
                    output frame_done, input ready);
    modport sink   (input valid, input feature_value, input feature_index,
                    input frame_done, output ready);
endinterface

interface cdf_cfg_if import cdf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/cepstral_delta_features_top.sv
// Channel   Dir  Fields                                        Item
// i_coef    in   coef_value[15:0]                              one coefficient, c0 first
// o_feat    out  feature_value[17:0] feature_index[5:0]        one feature element
//                frame_done
// i_cfg     in   index[1:0] data[3:0]                          one register write
//
// Each coefficient starts a burst of ring reads: the ring memory has two read ports
// and up to eight past frames are read per coefficient, two a cycle. Results leave
// one a cycle while o_feat.ready is high, from a 16-entry result queue, up to four
// per coefficient. Reset clears positions, counts and queue; the ring needs no
// clearing pass. i_coef.ready drops while the ring cannot take a new coefficient or
// the queue could not take the results of the items still in flight; i_cfg.ready stays high.
`timescale 1ns / 1ps

module cepstral_delta_features_top import cdf_pkg::*; #(
    parameter int CEP_SIZE        = CEP_SIZE_DFLT,
    parameter int MAX_HALF_WINDOW = MAX_HALF_WINDOW_DFLT,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DFLT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cdf_in_if.sink        i_coef,
    cdf_out_if.source     o_feat,
    cdf_cfg_if.sink       i_cfg
);

    localparam int KW  = (CEP_SIZE > 1) ? $clog2(CEP_SIZE) : 1;
    localparam int QAW = $clog2(RQ_DEPTH);

    t_mode      r_mode;
    logic [3:0] r_used;

    logic                             acc, free, busy, done, emit, pop, credit_ok;
    logic [KW-1:0]                    k;
    logic [NTAP-1:0][SAMPLE_BITS-1:0] taps;
    logic [2:0]                       push_n;
    t_res [MAX_RES-1:0]               ent;
    t_res                             head;
    logic [QAW:0]                     count;
    logic [1:0]                       pending;
    logic [QAW+1:0]                   need;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_LAYOUT39;
            r_used <= USED_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_FEATURE_MODE: r_mode <= t_mode'(i_cfg.data[1:0]);
                REG_COEFS_USED:   r_used <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    assign pending   = {1'b0, busy} + {1'b0, done};
    assign need      = (QAW + 2)'({1'b0, pending} + 3'd1) << 2;
    assign credit_ok = ((QAW + 2)'(count) + need) <= (QAW + 2)'(RQ_DEPTH);

    assign i_coef.ready = free && credit_ok;
    assign acc          = i_coef.valid && i_coef.ready;

    cdf_ring #(
        .CEP_SIZE        (CEP_SIZE),
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_coef  (i_coef.coef_value),
        .i_mode  (r_mode),
        .o_free  (free),
        .o_busy  (busy),
        .o_done  (done),
        .o_k     (k),
        .o_emit  (emit),
        .o_taps  (taps)
    );

    cdf_fmt #(
        .CEP_SIZE    (CEP_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_fmt (
        .i_vld    (done),
        .i_k      (k),
        .i_emit   (emit),
        .i_mode   (r_mode),
        .i_used   (r_used),
        .i_taps   (taps),
        .o_push_n (push_n),
        .o_ent    (ent)
    );

    assign pop = o_feat.valid && o_feat.ready;

    cdf_resq u_resq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (push_n),
        .i_ent    (ent),
        .i_pop    (pop),
        .o_head   (head),
        .o_count  (count)
    );

    assign o_feat.valid         = (count != '0);
    assign o_feat.feature_value = head.feature_value;
    assign o_feat.feature_index = head.feature_index;
    assign o_feat.frame_done    = head.frame_done;

endmodule

>>> rtl/cdf_ring.sv
`timescale 1ns / 1ps

module cdf_ring import cdf_pkg::*; #(
    parameter int CEP_SIZE        = CEP_SIZE_DFLT,
    parameter int MAX_HALF_WINDOW = MAX_HALF_WINDOW_DFLT,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DFLT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_acc,
    input  logic [COEF_W-1:0]                i_coef,
    input  t_mode                            i_mode,
    output logic                             o_free,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [((CEP_SIZE > 1) ? $clog2(CEP_SIZE) : 1)-1:0] o_k,
    output logic                             o_emit,
    output logic [NTAP-1:0][SAMPLE_BITS-1:0] o_taps
);

    localparam int NSLOT = 2 * MAX_HALF_WINDOW + 1;
    localparam int DEPTH = NSLOT * CEP_SIZE;
    localparam int KW    = (CEP_SIZE > 1) ? $clog2(CEP_SIZE) : 1;
    localparam int SW    = $clog2(NSLOT);
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(NSLOT + 1);
    localparam int XW    = (SAMPLE_BITS > COEF_W) ? SAMPLE_BITS : COEF_W;

    logic [SAMPLE_BITS-1:0] r_mem [0:DEPTH-1];

    logic [KW-1:0]          r_pos, n_pos;
    logic [SW-1:0]          r_newest, n_slot;
    logic [CW-1:0]          r_seen, n_seen;
    logic                   r_busy;
    logic [1:0]             r_phase;
    logic [KW-1:0]          r_k, r_o_k;
    logic [SW-1:0]          r_slot;
    logic                   r_emit, r_o_emit;
    logic [SAMPLE_BITS-1:0] r_sample, r_o_sample;
    logic                   r_rd_vld;
    logic [1:0]             r_rd_phase;
    logic [SAMPLE_BITS-1:0] r_rd_a, r_rd_b;
    logic [SAMPLE_BITS-1:0] r_tap [1:6];

    logic [XW-1:0]          coef_x;
    logic [SAMPLE_BITS-1:0] wr_data;
    logic [AW-1:0]          wr_addr, rd_addr_a, rd_addr_b;
    logic [3:0]             back_a, back_b;
    logic                   n_emit;

    function automatic logic [AW-1:0] f_addr(input logic [SW-1:0] slot,
                                             input logic [KW-1:0] k);
        return AW'(slot) * AW'(CEP_SIZE) + AW'(k);
    endfunction

    function automatic logic [SW-1:0] f_back(input logic [SW-1:0] slot,
                                             input logic [3:0] d);
        logic [SW:0] s;
        logic [SW:0] dx;
        logic [SW:0] r;
        s  = {1'b0, slot};
        dx = (SW + 1)'(d);
        if (s >= dx) begin
            r = s - dx;
        end else begin
            r = s + (SW + 1)'(NSLOT) - dx;
        end
        return r[SW-1:0];
    endfunction

    assign coef_x  = XW'(i_coef);
    assign wr_data = coef_x[SAMPLE_BITS-1:0];

    always_comb begin
        n_pos  = (r_pos == KW'(CEP_SIZE - 1)) ? '0 : r_pos + KW'(1);
        n_slot = r_newest;
        n_seen = r_seen;
        if (r_pos == '0) begin
            n_slot = (r_newest == SW'(NSLOT - 1)) ? '0 : r_newest + SW'(1);
            if (r_seen < CW'(NSLOT)) begin
                n_seen = r_seen + CW'(1);
            end
        end
        n_emit = (n_seen >= CW'(f_win_need(i_mode)));
    end

    assign wr_addr   = f_addr(n_slot, r_pos);
    assign back_a    = {1'b0, r_phase, 1'b0} + 4'd1;
    assign back_b    = {1'b0, r_phase, 1'b0} + 4'd2;
    assign rd_addr_a = f_addr(f_back(r_slot, back_a), r_k);
    assign rd_addr_b = f_addr(f_back(r_slot, back_b), r_k);

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (r_busy) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_newest   <= '0;
            r_seen     <= '0;
            r_busy     <= 1'b0;
            r_phase    <= 2'd0;
            r_rd_vld   <= 1'b0;
            r_rd_phase <= 2'd0;
        end else begin
            r_rd_vld   <= r_busy;
            r_rd_phase <= r_phase;
            if (i_acc) begin
                r_pos    <= n_pos;
                r_newest <= n_slot;
                r_seen   <= n_seen;
                r_busy   <= 1'b1;
                r_phase  <= 2'd0;
            end else if (r_busy) begin
                r_phase <= r_phase + 2'd1;
                if (r_phase == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_k      <= r_pos;
            r_slot   <= n_slot;
            r_emit   <= n_emit;
            r_sample <= wr_data;
        end
        if (r_busy && r_phase == 2'd3) begin
            r_o_k      <= r_k;
            r_o_emit   <= r_emit;
            r_o_sample <= r_sample;
        end
        if (r_rd_vld) begin
            unique case (r_rd_phase)
                2'd0: begin
                    r_tap[1] <= r_rd_a;
                    r_tap[2] <= r_rd_b;
                end
                2'd1: begin
                    r_tap[3] <= r_rd_a;
                    r_tap[4] <= r_rd_b;
                end
                2'd2: begin
                    r_tap[5] <= r_rd_a;
                    r_tap[6] <= r_rd_b;
                end
                2'd3: begin
                end
            endcase
        end
    end

    assign o_free    = !r_busy || r_phase == 2'd3;
    assign o_busy    = r_busy;
    assign o_done    = r_rd_vld && r_rd_phase == 2'd3;
    assign o_k       = r_o_k;
    assign o_emit    = r_o_emit;
    assign o_taps[0] = r_o_sample;
    assign o_taps[1] = r_tap[1];
    assign o_taps[2] = r_tap[2];
    assign o_taps[3] = r_tap[3];
    assign o_taps[4] = r_tap[4];
    assign o_taps[5] = r_tap[5];
    assign o_taps[6] = r_tap[6];
    assign o_taps[7] = r_rd_a;
    assign o_taps[8] = r_rd_b;

endmodule

>>> rtl/cdf_fmt.sv
`timescale 1ns / 1ps

module cdf_fmt import cdf_pkg::*; #(
    parameter int CEP_SIZE    = CEP_SIZE_DFLT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DFLT
) (
    input  logic                             i_vld,
    input  logic [((CEP_SIZE > 1) ? $clog2(CEP_SIZE) : 1)-1:0] i_k,
    input  logic                             i_emit,
    input  t_mode                            i_mode,
    input  logic [3:0]                       i_used,
    input  logic [NTAP-1:0][SAMPLE_BITS-1:0] i_taps,
    output logic [2:0]                       o_push_n,
    output t_res [MAX_RES-1:0]               o_ent
);

    localparam int KW  = (CEP_SIZE > 1) ? $clog2(CEP_SIZE) : 1;
    localparam int DW  = (SAMPLE_BITS + 2 > FEAT_W) ? SAMPLE_BITS + 2 : FEAT_W;
    localparam int IXW = 8;
    localparam int L   = CEP_SIZE - 1;

    localparam logic [IXW-1:0] I_L  = IXW'(L);
    localparam logic [IXW-1:0] I_2L = IXW'(2 * L);
    localparam logic [IXW-1:0] I_3L = IXW'(3 * L);

    logic signed [DW-1:0] t [0:NTAP-1];
    logic signed [DW-1:0] cep, dsh, dlg, ddv;
    logic [5:0]           used_c;
    logic [IXW-1:0]       k8, used8;
    logic                 last;

    function automatic t_res f_mk(input logic signed [DW-1:0] v,
                                  input logic [IXW-1:0] idx);
        t_res r;
        r.feature_value = v[FEAT_W-1:0];
        r.feature_index = idx[FIDX_W-1:0];
        r.frame_done    = 1'b0;
        return r;
    endfunction

    always_comb begin
        for (int i = 0; i < NTAP; i++) begin
            t[i] = DW'($signed(i_taps[i]));
        end
    end

    always_comb begin
        cep = t[0];
        dsh = t[0] - t[4];
        dlg = t[0] - t[8];
        ddv = '0;
        unique case (i_mode)
            MODE_CEP: begin
                cep = t[0];
            end
            MODE_CEP_DELTA: begin
                cep = t[2];
                dsh = t[0] - t[4];
            end
            MODE_LAYOUT39: begin
                cep = t[3];
                dsh = t[1] - t[5];
                ddv = (t[0] - t[4]) - (t[2] - t[6]);
            end
            MODE_LAYOUT51: begin
                cep = t[4];
                dsh = t[2] - t[6];
                ddv = (t[1] - t[5]) - (t[3] - t[7]);
            end
        endcase
    end

    always_comb begin
        used_c = {2'b00, i_used};
        if (used_c == 6'd0) begin
            used_c = 6'd1;
        end else if (used_c > 6'(CEP_SIZE)) begin
            used_c = 6'(CEP_SIZE);
        end
    end

    assign k8    = IXW'(i_k);
    assign used8 = IXW'(used_c);

    always_comb begin
        o_push_n = 3'd0;
        o_ent    = '0;
        last     = 1'b0;
        unique case (i_mode)
            MODE_CEP, MODE_CEP_DELTA: begin
                last = (6'(i_k) == used_c - 6'd1);
                if (6'(i_k) < used_c) begin
                    o_ent[0] = f_mk(cep, k8);
                    if (i_mode == MODE_CEP_DELTA) begin
                        o_ent[1]            = f_mk(dsh, used8 + k8);
                        o_ent[1].frame_done = last;
                        o_push_n            = 3'd2;
                    end else begin
                        o_ent[0].frame_done = last;
                        o_push_n            = 3'd1;
                    end
                end
            end
            MODE_LAYOUT39: begin
                last = (i_k == KW'(CEP_SIZE - 1));
                if (i_k == '0) begin
                    o_ent[0] = f_mk(cep, I_2L);
                    o_ent[1] = f_mk(dsh, I_2L + IXW'(1));
                    o_ent[2] = f_mk(ddv, I_2L + IXW'(2));
                end else begin
                    o_ent[0] = f_mk(cep, k8 - IXW'(1));
                    o_ent[1] = f_mk(dsh, I_L + k8 - IXW'(1));
                    o_ent[2] = f_mk(ddv, I_2L + IXW'(2) + k8);
                end
                o_ent[2].frame_done = last;
                o_push_n            = 3'd3;
            end
            MODE_LAYOUT51: begin
                last = (i_k == KW'(CEP_SIZE - 1));
                if (i_k == '0) begin
                    o_ent[0]            = f_mk(cep, I_3L);
                    o_ent[1]            = f_mk(dsh, I_3L + IXW'(1));
                    o_ent[2]            = f_mk(ddv, I_3L + IXW'(2));
                    o_ent[2].frame_done = last;
                    o_push_n            = 3'd3;
                end else begin
                    o_ent[0]            = f_mk(cep, k8 - IXW'(1));
                    o_ent[1]            = f_mk(dsh, I_L + k8 - IXW'(1));
                    o_ent[2]            = f_mk(dlg, I_2L + k8 - IXW'(1));
                    o_ent[3]            = f_mk(ddv, I_3L + IXW'(2) + k8);
                    o_ent[3].frame_done = last;
                    o_push_n            = 3'd4;
                end
            end
        endcase
        if (!(i_vld && i_emit)) begin
            o_push_n = 3'd0;
        end
    end

endmodule

>>> rtl/cdf_resq.sv
`timescale 1ns / 1ps

module cdf_resq import cdf_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [2:0]                 i_push_n,
    input  t_res [MAX_RES-1:0]         i_ent,
    input  logic                       i_pop,
    output t_res                       o_head,
    output logic [$clog2(RQ_DEPTH):0]  o_count
);

    localparam int QAW = $clog2(RQ_DEPTH);

    t_res         r_q [0:RQ_DEPTH-1];
    logic [QAW-1:0] r_head, r_tail;
    logic [QAW:0]   r_count;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (3'(i) < i_push_n) begin
                r_q[r_tail + QAW'(i)] <= i_ent[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + QAW'(i_push_n);
            r_count <= r_count + (QAW + 1)'(i_push_n) - (QAW + 1)'(i_pop);
            if (i_pop) begin
                r_head <= r_head + QAW'(1);
            end
        end
    end

    assign o_head  = r_q[r_head];
    assign o_count = r_count;

endmodule
